@@ hw/rtl/sri_pkg.sv @@
// sri_pkg: shared types for the segment versus rectangle hit test
// no dependencies; imported by sri_hit_stage and segment_rect_intersect

package sri_pkg;

   // one flag for each rectangle edge that the segment meets
   typedef struct packed {
      logic top;
      logic right;
      logic bottom;
      logic left;
   } edge_hits_type;

endpackage

@@ hw/rtl/sri_hit_stage.sv @@
// sri_hit_stage: ratio range tests for the four rectangle edges
// combinational; takes registered products and offsets, depends on sri_pkg

module sri_hit_stage #(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS:0]       sx,
   input  logic signed [COORD_BITS:0]       sy,
   input  logic signed [COORD_BITS:0]       oy_t,
   input  logic signed [COORD_BITS:0]       ox_l,
   input  logic signed [COORD_BITS+1:0]     oy_b,
   input  logic signed [COORD_BITS+1:0]     ox_r,
   input  logic signed [2*COORD_BITS+2:0]   p_ty_sx,
   input  logic signed [2*COORD_BITS+2:0]   p_by_sx,
   input  logic signed [2*COORD_BITS+2:0]   p_lx_sy,
   input  logic signed [2*COORD_BITS+2:0]   p_rx_sy,
   input  logic signed [2*COORD_BITS+2:0]   d_w,
   input  logic signed [2*COORD_BITS+2:0]   d_h,
   input  logic                             w_nz,
   input  logic                             h_nz,
   output sri_pkg::edge_hits_type           edge_hits
);
   import sri_pkg::*;

   localparam int PW = 2 * COORD_BITS + 4;

   logic signed [PW-1:0] q2_top;
   logic signed [PW-1:0] q2_right;
   logic signed [PW-1:0] q2_bottom;
   logic signed [PW-1:0] q2_left;
   logic signed [PW-1:0] sx_w;
   logic signed [PW-1:0] sy_w;
   logic signed [PW-1:0] dw_w;
   logic signed [PW-1:0] dh_w;
   logic                 sx_nz;
   logic                 sy_nz;

   // v/d in [0,1] for a nonzero d, without dividing
   function automatic logic in_range(input logic signed [PW-1:0] v,
                                     input logic signed [PW-1:0] d);
      logic res;
      if (!d[PW-1]) begin
         res = !v[PW-1] && (v <= d);
      end else begin
         res = (v[PW-1] || (v == '0)) && (v >= d);
      end
      return res;
   endfunction

   assign sx_w  = PW'(sx);
   assign sy_w  = PW'(sy);
   assign dw_w  = PW'(d_w);
   assign dh_w  = PW'(d_h);
   assign sx_nz = (sx != '0);
   assign sy_nz = (sy != '0);

   assign q2_top    = PW'(p_ty_sx) - PW'(p_lx_sy);
   assign q2_right  = PW'(p_ty_sx) - PW'(p_rx_sy);
   assign q2_bottom = PW'(p_by_sx) - PW'(p_rx_sy);
   assign q2_left   = PW'(p_by_sx) - PW'(p_lx_sy);

   // edge parameter tests use the offsets with the common size factor removed
   always_comb begin
      edge_hits.top    = w_nz && sy_nz
                         && in_range(PW'(oy_t), -sy_w)
                         && in_range(q2_top, -dw_w);
      edge_hits.right  = h_nz && sx_nz
                         && in_range(-PW'(ox_r), sx_w)
                         && in_range(q2_right, dh_w);
      edge_hits.bottom = w_nz && sy_nz
                         && in_range(-PW'(oy_b), sy_w)
                         && in_range(q2_bottom, dw_w);
      edge_hits.left   = h_nz && sx_nz
                         && in_range(PW'(ox_l), -sx_w)
                         && in_range(q2_left, -dh_w);
   end

endmodule

@@ hw/rtl/segment_rect_intersect.sv @@
// segment_rect_intersect: pipelined hit test of a line segment against a rectangle
// depends on sri_pkg and sri_hit_stage
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  segment endpoints, box corner and size
//   rsp      out        rsp_valid/rsp_stall  hit
//
// one item per cycle while rsp_stall is low
// stages: input register, offsets, multiplier bank, range tests into rsp
// each stage takes a new item when it is empty or the next one moves on
// reset empties the pipeline; payload registers are not reset
// req_stall rises only when all stages hold items and rsp_stall is high

module segment_rect_intersect #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_seg_ax,
   input  logic signed [COORD_BITS-1:0]  req_seg_ay,
   input  logic signed [COORD_BITS-1:0]  req_seg_bx,
   input  logic signed [COORD_BITS-1:0]  req_seg_by,
   input  logic signed [COORD_BITS-1:0]  req_box_left,
   input  logic signed [COORD_BITS-1:0]  req_box_top,
   input  logic        [COORD_BITS-2:0]  req_box_width,
   input  logic        [COORD_BITS-2:0]  req_box_height,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit
);
   import sri_pkg::*;

   localparam int N   = COORD_BITS;
   localparam int DW1 = N + 1;
   localparam int DW2 = N + 2;
   localparam int MW  = 2 * N + 3;

   // pipeline control
   logic in_valid_ff, dif_valid_ff, mul_valid_ff, rsp_valid_ff;
   logic in_en, dif_en, mul_en, rsp_en;

   // input register
   logic signed [N-1:0] in_ax_ff, in_ay_ff, in_bx_ff, in_by_ff, in_l_ff, in_t_ff;
   logic        [N-2:0] in_w_ff, in_h_ff;

   // offset stage
   logic signed [N-1:0]   w_s, h_s;
   logic signed [DW1-1:0] r_s, b_s;
   logic signed [DW1-1:0] sx_in, sy_in, oy_t_in, ox_l_in;
   logic signed [DW2-1:0] oy_b_in, ox_r_in;
   logic                  inside_in;
   logic signed [DW1-1:0] dif_sx_ff, dif_sy_ff, dif_oy_t_ff, dif_ox_l_ff;
   logic signed [DW2-1:0] dif_oy_b_ff, dif_ox_r_ff;
   logic        [N-2:0]   dif_w_ff, dif_h_ff;
   logic                  dif_inside_ff;

   // multiplier stage
   logic signed [N-1:0]   dw_s, dh_s;
   logic signed [MW-1:0]  p_ty_sx_in, p_by_sx_in, p_lx_sy_in, p_rx_sy_in, d_w_in, d_h_in;
   logic signed [MW-1:0]  mul_p_ty_sx_ff, mul_p_by_sx_ff, mul_p_lx_sy_ff, mul_p_rx_sy_ff;
   logic signed [MW-1:0]  mul_d_w_ff, mul_d_h_ff;
   logic signed [DW1-1:0] mul_sx_ff, mul_sy_ff, mul_oy_t_ff, mul_ox_l_ff;
   logic signed [DW2-1:0] mul_oy_b_ff, mul_ox_r_ff;
   logic                  mul_w_nz_ff, mul_h_nz_ff, mul_inside_ff;

   // result stage
   edge_hits_type edge_hits;
   logic          hit_in;
   logic          rsp_hit_ff;

   assign rsp_en  = !rsp_valid_ff || !rsp_stall;
   assign mul_en  = !mul_valid_ff || rsp_en;
   assign dif_en  = !dif_valid_ff || mul_en;
   assign in_en   = !in_valid_ff || dif_en;

   assign req_stall = !in_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         dif_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (dif_en) begin
            dif_valid_ff <= in_valid_ff;
         end
         if (mul_en) begin
            mul_valid_ff <= dif_valid_ff;
         end
         if (rsp_en) begin
            rsp_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_ax_ff <= req_seg_ax;
         in_ay_ff <= req_seg_ay;
         in_bx_ff <= req_seg_bx;
         in_by_ff <= req_seg_by;
         in_l_ff  <= req_box_left;
         in_t_ff  <= req_box_top;
         in_w_ff  <= req_box_width;
         in_h_ff  <= req_box_height;
      end
   end

   // offsets from the edge start corners and the half-open inside test
   assign w_s = {1'b0, in_w_ff};
   assign h_s = {1'b0, in_h_ff};
   assign r_s = DW1'(in_l_ff) + DW1'(w_s);
   assign b_s = DW1'(in_t_ff) + DW1'(h_s);

   assign sx_in   = DW1'(in_bx_ff) - DW1'(in_ax_ff);
   assign sy_in   = DW1'(in_by_ff) - DW1'(in_ay_ff);
   assign oy_t_in = DW1'(in_ay_ff) - DW1'(in_t_ff);
   assign ox_l_in = DW1'(in_ax_ff) - DW1'(in_l_ff);
   assign oy_b_in = DW2'(in_ay_ff) - DW2'(b_s);
   assign ox_r_in = DW2'(in_ax_ff) - DW2'(r_s);

   assign inside_in = (in_ax_ff >= in_l_ff) && (DW1'(in_ax_ff) < r_s)
                      && (in_ay_ff >= in_t_ff) && (DW1'(in_ay_ff) < b_s)
                      && (in_bx_ff >= in_l_ff) && (DW1'(in_bx_ff) < r_s)
                      && (in_by_ff >= in_t_ff) && (DW1'(in_by_ff) < b_s);

   always_ff @(posedge clock) begin
      if (dif_en) begin
         dif_sx_ff     <= sx_in;
         dif_sy_ff     <= sy_in;
         dif_oy_t_ff   <= oy_t_in;
         dif_ox_l_ff   <= ox_l_in;
         dif_oy_b_ff   <= oy_b_in;
         dif_ox_r_ff   <= ox_r_in;
         dif_w_ff      <= in_w_ff;
         dif_h_ff      <= in_h_ff;
         dif_inside_ff <= inside_in;
      end
   end

   // cross product terms and the edge denominators
   assign dw_s = {1'b0, dif_w_ff};
   assign dh_s = {1'b0, dif_h_ff};

   assign p_ty_sx_in = MW'(dif_oy_t_ff) * MW'(dif_sx_ff);
   assign p_by_sx_in = MW'(dif_oy_b_ff) * MW'(dif_sx_ff);
   assign p_lx_sy_in = MW'(dif_ox_l_ff) * MW'(dif_sy_ff);
   assign p_rx_sy_in = MW'(dif_ox_r_ff) * MW'(dif_sy_ff);
   assign d_w_in     = MW'(dif_sy_ff) * MW'(dw_s);
   assign d_h_in     = MW'(dif_sx_ff) * MW'(dh_s);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_p_ty_sx_ff <= p_ty_sx_in;
         mul_p_by_sx_ff <= p_by_sx_in;
         mul_p_lx_sy_ff <= p_lx_sy_in;
         mul_p_rx_sy_ff <= p_rx_sy_in;
         mul_d_w_ff     <= d_w_in;
         mul_d_h_ff     <= d_h_in;
         mul_sx_ff      <= dif_sx_ff;
         mul_sy_ff      <= dif_sy_ff;
         mul_oy_t_ff    <= dif_oy_t_ff;
         mul_ox_l_ff    <= dif_ox_l_ff;
         mul_oy_b_ff    <= dif_oy_b_ff;
         mul_ox_r_ff    <= dif_ox_r_ff;
         mul_w_nz_ff    <= (dif_w_ff != '0);
         mul_h_nz_ff    <= (dif_h_ff != '0);
         mul_inside_ff  <= dif_inside_ff;
      end
   end

   sri_hit_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_hit_stage (
      .sx        (mul_sx_ff),
      .sy        (mul_sy_ff),
      .oy_t      (mul_oy_t_ff),
      .ox_l      (mul_ox_l_ff),
      .oy_b      (mul_oy_b_ff),
      .ox_r      (mul_ox_r_ff),
      .p_ty_sx   (mul_p_ty_sx_ff),
      .p_by_sx   (mul_p_by_sx_ff),
      .p_lx_sy   (mul_p_lx_sy_ff),
      .p_rx_sy   (mul_p_rx_sy_ff),
      .d_w       (mul_d_w_ff),
      .d_h       (mul_d_h_ff),
      .w_nz      (mul_w_nz_ff),
      .h_nz      (mul_h_nz_ff),
      .edge_hits (edge_hits)
   );

   assign hit_in = edge_hits.top || edge_hits.right || edge_hits.bottom
                   || edge_hits.left || mul_inside_ff;

   always_ff @(posedge clock) begin
      if (rsp_en) begin
         rsp_hit_ff <= hit_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && dif_valid_ff && mul_valid_ff && rsp_valid_ff
                     && rsp_stall))
      else $error("req_stall with a free pipeline stage");

   a_no_item_lost: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && rsp_en) |=> rsp_valid_ff)
      else $error("item dropped between multiplier stage and rsp");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !dif_valid_ff && !mul_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_inside_needs_area: assert property (@(posedge clock) disable iff (reset)
      (mul_valid_ff && mul_inside_ff) |-> (mul_w_nz_ff && mul_h_nz_ff))
      else $error("inside flag set for a zero-size box");
`endif

endmodule

@@ bench/tb_segment_rect_intersect.sv @@
// tb_segment_rect_intersect: streams segment/box queries through the hit test and checks each hit
// depends on segment_rect_intersect (and sri_pkg through it); directed table first, then random
// queries, with random idling on both channels and one long hold-off on the result side

module tb_segment_rect_intersect;

   localparam int COORD_BITS       = 16;
   localparam int DIRECTED_ROWS    = 20;
   localparam int RANDOM_ITEMS     = 1000;
   localparam int TOTAL_ITEMS      = DIRECTED_ROWS + RANDOM_ITEMS;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int QUIET_FROM       = TOTAL_ITEMS - 150;
   localparam int DRAIN_CYCLES     = 12;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic        [COORD_BITS-2:0] width;
      logic        [COORD_BITS-2:0] height;
   } query_t;

   typedef enum logic [1:0] {
      PREDICTED,
      KNOWN_MISS,
      KNOWN_HIT
   } row_check_t;

   typedef struct packed {
      query_t     query;
      row_check_t check;
   } probe_row_t;

   localparam probe_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{'{-5, 5, 15, 5, 0, 0, 10, 10}, KNOWN_HIT},
      '{'{2, 2, 8, 8, 0, 0, 10, 10}, KNOWN_HIT},
      '{'{20, 20, 30, 30, 0, 0, 10, 10}, KNOWN_MISS},
      '{'{5, 5, 5, 5, 0, 0, 10, 10}, KNOWN_HIT},
      '{'{50, 50, 50, 50, 0, 0, 10, 10}, KNOWN_MISS},
      '{'{-5, -5, 5, 5, 0, 0, 0, 0}, KNOWN_MISS},
      '{'{-5, 5, 5, 5, 0, 0, 0, 10}, PREDICTED},
      '{'{5, -5, 5, 0, 0, 0, 10, 10}, KNOWN_HIT},
      '{'{-5, 0, 15, 0, 0, 0, 10, 10}, PREDICTED},
      '{'{20, 0, 30, 0, 0, 0, 10, 10}, PREDICTED},
      '{'{10, 5, 10, 5, 0, 0, 10, 10}, KNOWN_MISS},
      '{'{0, 0, 0, 0, 0, 0, 10, 10}, KNOWN_HIT},
      '{'{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767}, PREDICTED},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, KNOWN_HIT},
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, 0, 0}, KNOWN_MISS},
      '{'{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, PREDICTED},
      '{'{-32768, 32767, 32767, 32767, 0, 0, 32767, 32767}, PREDICTED},
      '{'{-20, -20, -20, 30, 0, 0, 10, 10}, PREDICTED},
      '{'{12, 3, 3, 12, 0, 0, 10, 10}, PREDICTED},
      '{'{-1, -1, 10, 10, 0, 0, 10, 10}, PREDICTED}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_hit;
   query_t     offered;
   row_check_t offered_check;
   logic       no_idle;
   logic       hold_wanted;
   logic       hold_done;
   int         error_count;
   bit         hit_queue[$];

   wire logic signed [COORD_BITS-1:0] req_seg_ax     = offered.ax;
   wire logic signed [COORD_BITS-1:0] req_seg_ay     = offered.ay;
   wire logic signed [COORD_BITS-1:0] req_seg_bx     = offered.bx;
   wire logic signed [COORD_BITS-1:0] req_seg_by     = offered.by;
   wire logic signed [COORD_BITS-1:0] req_box_left   = offered.left;
   wire logic signed [COORD_BITS-1:0] req_box_top    = offered.top;
   wire logic        [COORD_BITS-2:0] req_box_width  = offered.width;
   wire logic        [COORD_BITS-2:0] req_box_height = offered.height;

   segment_rect_intersect #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_seg_ax(req_seg_ax),
      .req_seg_ay(req_seg_ay),
      .req_seg_bx(req_seg_bx),
      .req_seg_by(req_seg_by),
      .req_box_left(req_box_left),
      .req_box_top(req_box_top),
      .req_box_width(req_box_width),
      .req_box_height(req_box_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit crosses_edge(input longint ax, ay, bx, by, e1x, e1y, e2x, e2y);
      longint ex, ey, sx, sy, ox, oy, den, q, q2;
      ex  = e2x - e1x;
      ey  = e2y - e1y;
      sx  = bx - ax;
      sy  = by - ay;
      ox  = ax - e1x;
      oy  = ay - e1y;
      den = sx * ey - sy * ex;
      q   = oy * ex - ox * ey;
      q2  = oy * sx - ox * sy;
      if (den > 0) begin
         return q >= 0 && q <= den && q2 >= 0 && q2 <= den;
      end
      if (den < 0) begin
         return q <= 0 && q >= den && q2 <= 0 && q2 >= den;
      end
      return 1'b0;
   endfunction

   function automatic bit point_in_box(input longint px, py, l, t, w, h);
      return l <= px && px < l + w && t <= py && py < t + h;
   endfunction

   function automatic bit segment_meets_box(input query_t q);
      longint ax, ay, bx, by, l, t, w, h, r, b;
      ax = longint'($signed(q.ax));
      ay = longint'($signed(q.ay));
      bx = longint'($signed(q.bx));
      by = longint'($signed(q.by));
      l  = longint'($signed(q.left));
      t  = longint'($signed(q.top));
      w  = longint'(q.width);
      h  = longint'(q.height);
      r  = l + w;
      b  = t + h;
      return crosses_edge(ax, ay, bx, by, l, t, r, t)
          || crosses_edge(ax, ay, bx, by, r, t, r, b)
          || crosses_edge(ax, ay, bx, by, r, b, l, b)
          || crosses_edge(ax, ay, bx, by, l, b, l, t)
          || (point_in_box(ax, ay, l, t, w, h) && point_in_box(bx, by, l, t, w, h));
   endfunction

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   // mostly queries near a box so that crossings, touches and inside cases are common
   function automatic query_t random_query();
      query_t q;
      int kind, l, t, w, h, m, ax, ay, bx, by;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         q.ax     = COORD_BITS'($urandom());
         q.ay     = COORD_BITS'($urandom());
         q.bx     = COORD_BITS'($urandom());
         q.by     = COORD_BITS'($urandom());
         q.left   = COORD_BITS'($urandom());
         q.top    = COORD_BITS'($urandom());
         q.width  = (COORD_BITS-1)'($urandom());
         q.height = (COORD_BITS-1)'($urandom());
         return q;
      end
      l  = pick(-1000, 1000);
      t  = pick(-1000, 1000);
      w  = (kind == 9) ? pick(0, 32767) : pick(0, 48);
      h  = (kind == 9) ? pick(0, 32767) : pick(0, 48);
      m  = (kind == 6 || kind == 7) ? 0 : 24;
      ax = pick(l - m, l + w + m);
      ay = pick(t - m, t + h + m);
      bx = pick(l - m, l + w + m);
      by = pick(t - m, t + h + m);
      if (kind == 8) begin
         if ($urandom_range(0, 1) == 1) begin
            ay = ($urandom_range(0, 1) == 1) ? t : t + h;
            by = ay;
         end else begin
            ax = ($urandom_range(0, 1) == 1) ? l : l + w;
            bx = ax;
         end
      end
      q.ax     = COORD_BITS'(ax);
      q.ay     = COORD_BITS'(ay);
      q.bx     = COORD_BITS'(bx);
      q.by     = COORD_BITS'(by);
      q.left   = COORD_BITS'(l);
      q.top    = COORD_BITS'(t);
      q.width  = (COORD_BITS-1)'(w);
      q.height = (COORD_BITS-1)'(h);
      return q;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic offer_query(input query_t q, input row_check_t chk);
      int gap;
      gap = (!no_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      offered       = q;
      offered_check = chk;
      req_valid     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      bit wanted;
      if (!reset && req_valid && !req_stall) begin
         case (offered_check)
            KNOWN_HIT:  hit_queue.push_back(1'b1);
            KNOWN_MISS: hit_queue.push_back(1'b0);
            default:    hit_queue.push_back(segment_meets_box(offered));
         endcase
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_queue.size() == 0) begin
            report_mismatch("result item with no query pending");
         end else begin
            wanted = hit_queue.pop_front();
            if (rsp_hit !== wanted) begin
               report_mismatch($sformatf("hit %b, wanted %b", rsp_hit, wanted));
            end
         end
      end
   end

   initial begin
      int burst;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            // long hold-off so the pipeline fills and pushes back on req
            rsp_stall = 1'b1;
            for (burst = 0; burst < LONG_HOLD_CYCLES; burst++) @(negedge clock);
            rsp_stall = 1'b0;
            hold_done = 1'b1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      int n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      offered       = '0;
      offered_check = PREDICTED;
      no_idle       = 1'b0;
      hold_wanted   = 1'b0;
      error_count   = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (n = 0; n < TOTAL_ITEMS; n++) begin
         no_idle = (n >= QUIET_FROM) || ((n / 64) % 4 == 3);
         if (n == LONG_HOLD_AT) begin
            hold_wanted = 1'b1;
         end
         if (n < DIRECTED_ROWS) begin
            offer_query(DIRECTED[n].query, DIRECTED[n].check);
         end else begin
            offer_query(random_query(), PREDICTED);
         end
      end
      @(negedge clock);
      req_valid = 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[segment_rect_intersect] OK");
      end else begin
         $display("[segment_rect_intersect] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[segment_rect_intersect] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sri_pkg.sv
hw/rtl/sri_hit_stage.sv
hw/rtl/segment_rect_intersect.sv
bench/tb_segment_rect_intersect.sv
